FILE: sv/linear_probe_hash_insert_macros.svh
// assertion macros shared by the linear_probe_hash_insert checker
// the including scope provides clk and rst_n
`ifndef LINEAR_PROBE_HASH_INSERT_MACROS_SVH
`define LINEAR_PROBE_HASH_INSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LPH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lph_pkg.sv
// shared types and constants for the linear probing hash insert block
// no dependencies
`default_nettype none

package lph_pkg;

    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 64;
    localparam int SIZE_W    = 5;
    localparam int SLOT_W    = 4;
    // largest table the five-bit size register can select
    localparam int MAX_SLOTS = 31;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // remainder unit: padded dividend, digits retired per cycle, step count
    localparam int MOD_W      = 32;
    localparam int MOD_DIGITS = 4;
    localparam int MOD_STEPS  = MOD_W / MOD_DIGITS;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic    load;
        logic    probe_init;
        logic    rd;
        logic    commit;
        logic    advance;
        logic    report;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic empty;
        logic match;
        logic last;
    } sts_t;

endpackage

`default_nettype wire

FILE: sv/lph_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/lph_mod.sv
// multi-cycle remainder unit: key modulo table size, four bits per cycle
// depends on lph_pkg
`default_nettype none

module lph_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lph_pkg::KEY_W-1:0]   dividend,
    input  wire logic [lph_pkg::SIZE_W-1:0]  divisor,
    output logic                             done,
    output logic      [lph_pkg::SIZE_W-1:0]  rem
);

    localparam logic [lph_pkg::MOD_CNT_W-1:0] CNT_LAST =
        lph_pkg::MOD_CNT_W'(lph_pkg::MOD_STEPS - 1);

    logic [lph_pkg::MOD_W-1:0]     shift_reg;
    logic [lph_pkg::SIZE_W-1:0]    div_reg;
    logic [lph_pkg::SIZE_W-1:0]    rem_reg;
    logic [lph_pkg::SIZE_W-1:0]    rem_next;
    logic [lph_pkg::MOD_CNT_W-1:0] cnt_reg;
    logic                          active_reg;
    logic                          done_reg;

    // restoring remainder steps; partial remainder stays below the divisor
    always_comb
    begin
        logic [lph_pkg::SIZE_W:0]   t;
        logic [lph_pkg::SIZE_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < lph_pkg::MOD_DIGITS; i++)
        begin
            t = {r, shift_reg[lph_pkg::MOD_W-1-i]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[lph_pkg::SIZE_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= lph_pkg::MOD_W'(dividend);
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (active_reg)
        begin
            shift_reg <= shift_reg << lph_pkg::MOD_DIGITS;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: sv/lph_dp.sv
// datapath: size register, remainder unit, probe pointer, used bits, slot ram
// depends on lph_pkg, lph_mod, lph_ram
`default_nettype none

module lph_dp #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lph_pkg::cmd_t                cmd,
    output lph_pkg::sts_t                     sts,
    input  wire logic                         cfg_we,
    input  wire logic [lph_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic [lph_pkg::KEY_W-1:0]    key,
    input  wire logic [lph_pkg::VALUE_W-1:0]  value,
    output logic                              done,
    output logic      [1:0]                   status,
    output logic      [lph_pkg::SLOT_W-1:0]   slot
);

    localparam int AW = $clog2(SLOTS);
    localparam int EW = lph_pkg::KEY_W + VALUE_BITS;
    localparam logic [lph_pkg::SIZE_W-1:0] SIZE_MAX = lph_pkg::SIZE_W'(SLOTS);

    logic [lph_pkg::SIZE_W-1:0] size_reg;
    logic [lph_pkg::SIZE_W-1:0] eff_size;
    logic [lph_pkg::SIZE_W-1:0] esize_reg;
    logic [lph_pkg::KEY_W-1:0]  key_reg;
    logic [VALUE_BITS-1:0]      val_reg;
    logic [AW-1:0]              pos_reg;
    logic [lph_pkg::SIZE_W-1:0] pos_inc;
    logic [lph_pkg::SIZE_W-1:0] cnt_reg;
    logic [SLOTS-1:0]           used_reg;
    logic                       used_q_reg;
    logic                       done_reg;
    lph_pkg::status_t           status_reg;
    logic [lph_pkg::SLOT_W-1:0] slot_reg;
    logic                       mod_done;
    logic [lph_pkg::SIZE_W-1:0] mod_rem;
    logic [EW-1:0]              rd_entry;
    logic [lph_pkg::KEY_W-1:0]  rd_key;

    // zero acts as one, anything above the slot count is clamped
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = lph_pkg::SIZE_W'(1);
        end
        else if (size_reg > SIZE_MAX)
        begin
            eff_size = SIZE_MAX;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    lph_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (key),
        .divisor  (eff_size),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    lph_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (pos_reg),
        .wdata ({key_reg, val_reg}),
        .re    (cmd.rd),
        .raddr (pos_reg),
        .rdata (rd_entry)
    );

    assign rd_key  = rd_entry[EW-1:VALUE_BITS];
    assign pos_inc = lph_pkg::SIZE_W'(pos_reg) + 1'b1;

    assign sts.mod_done = mod_done;
    assign sts.empty    = !used_q_reg;
    assign sts.match    = (rd_key == key_reg);
    assign sts.last     = ((cnt_reg + 1'b1) == esize_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= lph_pkg::SIZE_RESET;
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                used_reg[pos_reg] <= 1'b1;
            end
            done_reg <= cmd.report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key;
            val_reg   <= value[VALUE_BITS-1:0];
            esize_reg <= eff_size;
        end
        if (cmd.probe_init)
        begin
            pos_reg <= AW'(mod_rem);
            cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            // wrap back to slot zero at the end of the active range
            pos_reg <= (pos_inc == esize_reg) ? '0 : AW'(pos_inc);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            used_q_reg <= used_reg[pos_reg];
        end
        if (cmd.report)
        begin
            status_reg <= cmd.code;
            slot_reg   <= (cmd.code == lph_pkg::ST_FULL) ? '0 : lph_pkg::SLOT_W'(pos_reg);
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

endmodule

`default_nettype wire

FILE: sv/lph_ctrl.sv
// controller state machine: sequences remainder, probe reads and commit
// depends on lph_pkg
`default_nettype none

module lph_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire lph_pkg::sts_t  sts,
    output lph_pkg::cmd_t       cmd
);

    lph_pkg::state_t state_reg;
    lph_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lph_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lph_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = lph_pkg::S_MOD;
                end
            end
            lph_pkg::S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = lph_pkg::S_READ;
                end
            end
            lph_pkg::S_READ:
            begin
                state_next = lph_pkg::S_CHECK;
            end
            lph_pkg::S_CHECK:
            begin
                if (sts.empty || sts.match || sts.last)
                begin
                    state_next = lph_pkg::S_IDLE;
                end
                else
                begin
                    state_next = lph_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = lph_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.code = lph_pkg::ST_INSERTED;
        unique case (state_reg)
            lph_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            lph_pkg::S_MOD:
            begin
                cmd.probe_init = sts.mod_done;
            end
            lph_pkg::S_READ:
            begin
                cmd.rd = 1'b1;
            end
            lph_pkg::S_CHECK:
            begin
                // an empty slot wins over the stale key it may still hold
                if (sts.empty)
                begin
                    cmd.commit = 1'b1;
                    cmd.report = 1'b1;
                    cmd.code   = lph_pkg::ST_INSERTED;
                end
                else if (sts.match)
                begin
                    cmd.commit = 1'b1;
                    cmd.report = 1'b1;
                    cmd.code   = lph_pkg::ST_UPDATED;
                end
                else if (sts.last)
                begin
                    cmd.report = 1'b1;
                    cmd.code   = lph_pkg::ST_FULL;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != lph_pkg::S_IDLE);

endmodule

`default_nettype wire

FILE: sv/linear_probe_hash_insert.sv
// top level of the linear probing hash insert block
// depends on lph_pkg, lph_ctrl, lph_dp (and through it lph_mod, lph_ram)
//
// channel   ports                      handshake
// config    cfg_we, cfg_data           written at clock edge with cfg_we high
// request   key, value                 taken at clock edge with start high, busy low
// result    status, slot               valid for the one cycle that done is high
//
// an item runs the remainder unit first and then probes the table, from 1 to the
// active table size probes; each probe is the registered read of the slot ram and
// the compare that follows
// reset clears the used bits and returns table_size to 16; no clearing pass
// the result cannot be stalled; a new item may start in the cycle done shows
`default_nettype none

module linear_probe_hash_insert #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [lph_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [lph_pkg::KEY_W-1:0]    key,
    input  wire logic [lph_pkg::VALUE_W-1:0]  value,
    output logic                              done,
    output logic      [1:0]                   status,
    output logic      [lph_pkg::SLOT_W-1:0]   slot
);

    // the size register cannot select more than MAX_SLOTS slots
    localparam int SLOTS = (TABLE_DEPTH < lph_pkg::MAX_SLOTS) ? TABLE_DEPTH
                                                              : lph_pkg::MAX_SLOTS;

    lph_pkg::cmd_t cmd;
    lph_pkg::sts_t sts;

    lph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    lph_dp #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .key      (key),
        .value    (value),
        .done     (done),
        .status   (status),
        .slot     (slot)
    );

endmodule

`default_nettype wire

FILE: sv/lph_chk.sv
// port-level checker for linear_probe_hash_insert, attached by bind
// depends on lph_pkg and linear_probe_hash_insert_macros.svh
`default_nettype none
`include "linear_probe_hash_insert_macros.svh"

module lph_chk (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic [1:0]                  status,
    input wire logic [lph_pkg::SLOT_W-1:0]  slot
);

    logic pending_reg;

    // one transaction in flight between acceptance and its result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (start && !busy)
        begin
            pending_reg <= 1'b1;
        end
        else if (done)
        begin
            pending_reg <= 1'b0;
        end
    end

    `LPH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")
    `LPH_ASSERT_SAME(a_done_pending, done, pending_reg, "result without a transaction")
    `LPH_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `LPH_ASSERT_SAME(a_full_slot, done && status == lph_pkg::ST_FULL, slot == '0, "full with slot")

endmodule

bind linear_probe_hash_insert lph_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .slot   (slot)
);

`default_nettype wire

FILE: tb/sv/linear_probe_hash_insert_tb.sv
`timescale 1ns / 1ps
// testbench for linear_probe_hash_insert: a directed table, then random phases at several
// table sizes, every result checked against the in-bench table model or a hand-typed row
// depends on lph_pkg and the linear_probe_hash_insert rtl

module linear_probe_hash_insert_tb;
    import lph_pkg::*;

    localparam int SLOTS           = 16;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_PHASE    = 12;

    typedef struct packed {
        status_t           st;
        logic [SLOT_W-1:0] sl;
    } outcome_t;

    typedef struct packed {
        logic               is_cfg;
        logic [SIZE_W-1:0]  size;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        logic               typed;
        outcome_t           res;
    } dir_row_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [SIZE_W-1:0]  cfg_data = '0;
    logic               start    = 1'b0;
    logic [KEY_W-1:0]   key      = '0;
    logic [VALUE_W-1:0] value    = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;

    // hand-typed expectation that rides along with the request
    logic     row_typed = 1'b0;
    outcome_t row_res   = '0;

    // model of the table
    logic [SIZE_W-1:0]  size_reg;
    logic               slot_used  [SLOTS];
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VALUE_W-1:0] slot_value [SLOTS];

    outcome_t expected_outcomes [$];
    int       errors      = 0;
    int       idle_cycles = 0;
    int       n_requests  = 0;
    int       n_inserted  = 0;
    int       n_updated   = 0;
    int       n_full      = 0;

    linear_probe_hash_insert uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .key      (key),
        .value    (value),
        .done     (done),
        .status   (status),
        .slot     (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic outcome_t probe_insert(input logic [KEY_W-1:0] k,
                                              input logic [VALUE_W-1:0] v);
        int       span;
        int       pos;
        outcome_t r;
        span = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : int'(size_reg);
        pos  = int'({1'b0, k}) % span;
        for (int n = 0; n < span; n++)
        begin
            if (!slot_used[pos])
            begin
                slot_used[pos]  = 1'b1;
                slot_key[pos]   = k;
                slot_value[pos] = v;
                r = '{ST_INSERTED, SLOT_W'(pos)};
                return r;
            end
            if (slot_key[pos] == k)
            begin
                slot_value[pos] = v;
                r = '{ST_UPDATED, SLOT_W'(pos)};
                return r;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        r = '{ST_FULL, '0};
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
    endfunction

    // four in ten random keys reuse a stored key when one exists, so updates stay common
    function automatic logic [KEY_W-1:0] pick_key();
        int live [$];
        int r;
        r = $urandom_range(0, 9);
        foreach (slot_used[i])
            if (slot_used[i])
                live.push_back(i);
        if (r < 4 && live.size() > 0)
            return slot_key[live[$urandom_range(0, live.size() - 1)]];
        if (r < 6)
            return KEY_W'($urandom_range(0, 40));
        if (r < 9)
            return KEY_W'($urandom);
        return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    function automatic dir_row_t cfg_row(input logic [SIZE_W-1:0] size);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.size   = size;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic [KEY_W-1:0] k,
                                          input logic [VALUE_W-1:0] v,
                                          input logic typed, input status_t st,
                                          input logic [SLOT_W-1:0] sl);
        dir_row_t r;
        r = '0;
        r.k     = k;
        r.v     = v;
        r.typed = typed;
        r.res   = '{st, sl};
        return r;
    endfunction

    // result check, size tracking, model update on accepted transactions, and the stall watchdog
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (cfg_we)
                size_reg = cfg_data;
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                    note_mismatch($sformatf("result status %0d slot %0d with nothing pending",
                                            status, slot));
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (status !== want.st || slot !== want.sl)
                        note_mismatch($sformatf("status %0d slot %0d, expected status %0d slot %0d",
                                                status, slot, want.st, want.sl));
                end
            end
            if (start && !busy)
            begin
                want = probe_insert(key, value);
                if (row_typed)
                    want = row_res;
                expected_outcomes.push_back(want);
                n_requests++;
                case (want.st)
                    ST_INSERTED: n_inserted++;
                    ST_UPDATED:  n_updated++;
                    default:     n_full++;
                endcase
            end
        end
        if (done || (start && !busy))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v,
                             input logic typed, input outcome_t res);
        @(negedge clk);
        key       = k;
        value     = v;
        row_typed = typed;
        row_res   = res;
        start     = 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // gap either right after acceptance or once the block has gone idle
    task automatic hold_off(input int cycles, input bit after_busy);
        @(negedge clk);
        start = 1'b0;
        if (after_busy)
        begin
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
        repeat (cycles - 1) @(negedge clk);
    endtask

    // size changes only with every result in hand
    task automatic set_table_size(input logic [SIZE_W-1:0] size);
        @(negedge clk);
        start = 1'b0;
        while (expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = size;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        dir_row_t          rows [21];
        logic [SIZE_W-1:0] phase_size [PHASES];
        logic [SIZE_W-1:0] size;

        rows = '{
            // size zero acts as one slot
            cfg_row(5'd0),
            item_row(31'd0, 64'd0, 1'b1, ST_INSERTED, 4'd0),
            item_row('1, '1, 1'b1, ST_FULL, 4'd0),
            item_row(31'd0, '1, 1'b1, ST_UPDATED, 4'd0),
            // oversized table acts as the full depth
            cfg_row(5'd17),
            item_row('1, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED, 4'd15),
            item_row(31'd31, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_INSERTED, 4'd1),
            item_row(31'd15, 64'h0123_4567_89AB_CDEF, 1'b0, ST_INSERTED, 4'd0),
            cfg_row(5'd31),
            item_row(31'd31, 64'd0, 1'b0, ST_INSERTED, 4'd0),
            // shrink: upper slots kept but out of reach
            cfg_row(5'd3),
            item_row(31'd5, '1, 1'b1, ST_FULL, 4'd0),
            item_row(31'd15, 64'd1, 1'b0, ST_INSERTED, 4'd0),
            cfg_row(5'd16),
            item_row('1, 64'd0, 1'b1, ST_UPDATED, 4'd15),
            cfg_row(5'd1),
            item_row(31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_FULL, 4'd0),
            cfg_row(5'd16),
            item_row(31'h5555_5555, 64'h5555_5555_5555_5555, 1'b0, ST_INSERTED, 4'd0),
            item_row(31'd21, 64'hFFFF_0000_FFFF_0000, 1'b0, ST_INSERTED, 4'd0),
            item_row(31'h4000_0000, 64'h8000_0000_0000_0001, 1'b0, ST_INSERTED, 4'd0)
        };
        phase_size = '{5'd4, 5'd6, 5'd2, 5'd8, 5'd0, 5'd10, 5'd12,
                       5'd1, 5'd14, 5'd17, 5'd31, 5'd16, 5'd0, 5'd16};

        size_reg = SIZE_RESET;
        foreach (slot_used[i])
        begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                set_table_size(rows[i].size);
            else
            begin
                send_item(rows[i].k, rows[i].v, rows[i].typed, rows[i].res);
                if ($urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 3), $urandom_range(0, 1));
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            size = (p == RANDOM_PHASE) ? SIZE_W'($urandom_range(0, 31)) : phase_size[p];
            set_table_size(size);
            for (int j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                send_item(pick_key(), {$urandom, $urandom}, 1'b0, outcome_t'('0));
                // the last phase runs back to back
                if (p < PHASES - 1 && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 3), $urandom_range(0, 1));
            end
        end

        @(negedge clk);
        start     = 1'b0;
        row_typed = 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests: %0d inserts, %0d updates, %0d table-full outcomes",
                 n_requests, n_inserted, n_updated, n_full);
        $display("tb: table sizes 0 to 31 incl. clamped and shrunk tables, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
